/* hdl/sae_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sae_pkg
// Shared types and opcode constants for the SPARC integer ALU execute block.
// ----------------------------------------------------------------------------
package sae_pkg;

   localparam int NumRegs   = 32;
   localparam int RegIdxW   = 5;
   localparam int DataW     = 32;
   localparam int ReqDataW  = 32;
   localparam int RspDataW  = 40;

   localparam logic [1:0] OP_FMT2  = 2'd0;
   localparam logic [1:0] OP_ALU   = 2'd2;
   localparam logic [1:0] OP_MEM   = 2'd3;
   localparam logic [2:0] OP2_SETHI = 3'd4;

   localparam logic [5:0] OP3_ADD  = 6'd0;
   localparam logic [5:0] OP3_AND  = 6'd1;
   localparam logic [5:0] OP3_OR   = 6'd2;
   localparam logic [5:0] OP3_XOR  = 6'd3;
   localparam logic [5:0] OP3_SUB  = 6'd4;
   localparam logic [5:0] OP3_ANDN = 6'd5;
   localparam logic [5:0] OP3_ORN  = 6'd6;
   localparam logic [5:0] OP3_XNOR = 6'd7;
   localparam logic [5:0] OP3_ADDX = 6'd8;
   localparam logic [5:0] OP3_SUBX = 6'd12;

   typedef logic [RegIdxW-1:0] reg_idx_type;
   typedef logic [DataW-1:0]   word_type;

   typedef struct packed {
      logic     wr;
      word_type value;
   } alu_result_type;

   function automatic reg_idx_type rd_of(input word_type ir);
      return ir[29:25];
   endfunction

   function automatic reg_idx_type rs1_of(input word_type ir);
      return ir[18:14];
   endfunction

   function automatic reg_idx_type rs2_of(input word_type ir);
      return ir[4:0];
   endfunction

endpackage
`default_nettype wire

/* hdl/sae_alu.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sae_alu
// Decode and compute for SETHI and format-3 ALU operations.
// ----------------------------------------------------------------------------
module sae_alu (
   input  wire  sae_pkg::word_type       instr,
   input  wire                           carry,
   input  wire  sae_pkg::word_type       rs1_value,
   input  wire  sae_pkg::word_type       rs2_value,
   output       sae_pkg::alu_result_type result
);
   import sae_pkg::*;

   logic [1:0] op;
   logic [2:0] op2;
   logic [5:0] op3;
   word_type   opb;
   word_type   cin_w;

   assign op    = instr[31:30];
   assign op2   = instr[24:22];
   assign op3   = instr[24:19];
   assign cin_w = {{(DataW-1){1'b0}}, carry};
   // simm13, sign-extended
   assign opb   = instr[13] ? {{(DataW-13){instr[12]}}, instr[12:0]} : rs2_value;

   always_comb begin
      result.wr    = 1'b0;
      result.value = '0;
      if (op == OP_FMT2) begin
         if (op2 == OP2_SETHI) begin
            result.wr    = 1'b1;
            result.value = {instr[21:0], 10'd0};
         end
      end else if (op == OP_ALU || op == OP_MEM) begin
         result.wr = 1'b1;
         case (op3)
            OP3_ADD:  result.value = rs1_value + opb;
            OP3_AND:  result.value = rs1_value & opb;
            OP3_OR:   result.value = rs1_value | opb;
            OP3_XOR:  result.value = rs1_value ^ opb;
            OP3_SUB:  result.value = rs1_value - opb;
            OP3_ANDN: result.value = rs1_value & ~opb;
            OP3_ORN:  result.value = rs1_value | ~opb;
            OP3_XNOR: result.value = rs1_value ^ ~opb;
            OP3_ADDX: result.value = rs1_value + opb + cin_w;
            OP3_SUBX: result.value = rs1_value - opb - cin_w;
            default: begin
               result.wr    = 1'b0;
               result.value = '0;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

/* hdl/sparc_alu_execute.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sparc_alu_execute
// SPARC integer execute stage with a 32 x 32-bit register file.
// ----------------------------------------------------------------------------
// One item is accepted per clock while the result is not stalled. Its result
// item passes from the operand registers into the result register before it
// is presented. The register file is read at the accept edge into operand
// registers, the ALU runs in the next cycle and writes back as the result
// register loads. A write by the item in the ALU cycle is forwarded to the
// item being accepted. r0 reads as zero and is never stored. Per-entry valid
// bits give all-zero after reset, so no clearing pass is needed.
module sparc_alu_execute (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire  [sae_pkg::ReqDataW-1:0]   req_tdata,   // [31:0] instruction
   input  wire                            req_tuser,   // [0] carry_in
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   // [4:0] dest_index, [36:5] write_value, [39:37] zero
   output logic [sae_pkg::RspDataW-1:0]   rsp_tdata,
   output logic                           rsp_tuser    // [0] write_enable
);
   import sae_pkg::*;

   word_type       regfile_ff [NumRegs];
   logic [NumRegs-1:0] valid_ff;

   logic           s1_valid_ff;
   word_type       s1_instr_ff;
   logic           s1_carry_ff;
   word_type       rd_a_ff, rd_b_ff;
   logic           vld_a_ff, vld_b_ff;
   logic           fwd_a_ff, fwd_b_ff;

   logic           rsp_valid_ff;
   logic           rsp_we_ff;
   reg_idx_type    rsp_dest_ff;
   word_type       rsp_value_ff;

   logic           advance, accept, wb_en;
   logic           fwd_a_in, fwd_b_in;
   reg_idx_type    rs1_in, rs2_in, s1_rd;
   word_type       opa, opb;
   alu_result_type res;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign rs1_in = rs1_of(req_tdata);
   assign rs2_in = rs2_of(req_tdata);
   assign s1_rd  = rd_of(s1_instr_ff);
   assign wb_en  = advance && res.wr && (s1_rd != '0);

   assign fwd_a_in = wb_en && (s1_rd == rs1_in);
   assign fwd_b_in = wb_en && (s1_rd == rs2_in);

   assign opa = fwd_a_ff ? rsp_value_ff : (vld_a_ff ? rd_a_ff : '0);
   assign opb = fwd_b_ff ? rsp_value_ff : (vld_b_ff ? rd_b_ff : '0);

   sae_alu u_alu (
      .instr     (s1_instr_ff),
      .carry     (s1_carry_ff),
      .rs1_value (opa),
      .rs2_value (opb),
      .result    (res)
   );

   always_ff @(posedge clock) begin
      if (wb_en) begin
         regfile_ff[s1_rd] <= res.value;
      end
      if (accept) begin
         rd_a_ff <= regfile_ff[rs1_in];
         rd_b_ff <= regfile_ff[rs2_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wb_en) begin
         valid_ff[s1_rd] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_instr_ff <= req_tdata;
         s1_carry_ff <= req_tuser;
         vld_a_ff    <= valid_ff[rs1_in];
         vld_b_ff    <= valid_ff[rs2_in];
         fwd_a_ff    <= fwd_a_in;
         fwd_b_ff    <= fwd_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_we_ff    <= res.wr;
         rsp_dest_ff  <= s1_rd;
         rsp_value_ff <= res.value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_we_ff;
   assign rsp_tdata  = {3'd0, rsp_value_ff, rsp_dest_ff};

   // r0 is never stored
   a_r0_never_valid: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0])
      else $error("r0 marked as written");

   // no write means a zero value
   a_nowrite_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_we_ff |-> rsp_value_ff == '0)
      else $error("non-zero value without write");

   // a stalled result blocks a held item, and the held item then blocks input
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input taken while pipeline stalled");

   // forwarding only happens alongside a write-back
   a_fwd_with_wb: assert property (@(posedge clock) disable iff (reset)
      accept && (fwd_a_in || fwd_b_in) |=> rsp_valid_ff && rsp_we_ff)
      else $error("forward without write-back");

endmodule
`default_nettype wire
